// ===== rtl/mandelbrot_pixel_colorizer_macros.svh =====
// Assertion helpers for the colorizer RTL, which checks itself.
`ifndef MANDELBROT_PIXEL_COLORIZER_MACROS_SVH
`define MANDELBROT_PIXEL_COLORIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpc_pkg.sv =====
package mpc_pkg;

    localparam int COORD_W   = 32;   // signed Q4.28 coordinate
    localparam int FRAC_W    = 28;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SQ_W      = PROD_W - FRAC_W;   // product after floor shift
    localparam int WIDE_W    = 49;   // headroom for sums before saturation
    localparam int STEP_W    = 31;
    localparam int DIM_W     = 11;
    localparam int PIX_W     = 10;
    localparam int ITER_W    = 10;
    localparam int COLOR_W   = 8;
    localparam int DVD_W     = ITER_W + 8;        // it * 255
    localparam int DIV_CNT_W = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd5;

    // 4.0 in Q.28 at the width of xx + yy
    localparam logic signed [SQ_W:0] ESCAPE_LIMIT = (SQ_W+1)'(4) <<< FRAC_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [ITER_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
    } div_rsp_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic [WIDE_W-COORD_W:0] top;
        top = v[WIDE_W-1:COORD_W-1];
        if ((&top) || !(|top))
            return v[COORD_W-1:0];
        else if (v[WIDE_W-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/mpc_mul_unit.sv =====
module mpc_mul_unit
    import mpc_pkg::*;
(
    input  logic                      clk,
    input  mul_req_t                  req,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // one signed 32x32 product per cycle, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/mpc_divider.sv =====
module mpc_divider
    import mpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ITER_W-1:0]    rem_reg;
    logic [ITER_W-1:0]    dvs_reg;
    logic [DVD_W-1:0]     quo_reg;

    logic [ITER_W:0] rem_shift;
    logic [ITER_W:0] rem_sub;
    logic            fits;

    // restoring division, one quotient bit per cycle while busy
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[ITER_W-1:0] : rem_shift[ITER_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/mandelbrot_pixel_colorizer.sv =====
// Each pixel runs through the setup states, then the iteration loop; a point that
// escapes also waits for the serial divide that sets its color.
// A new pixel is taken only back in ST_IDLE; the single shared multiplier
// sets the iteration step (x*x, y*y, x*y, then update).
// Reset: rst_n is asynchronous and active low; the configuration registers return to their default view.
`include "mandelbrot_pixel_colorizer_macros.svh"

module mandelbrot_pixel_colorizer
    import mpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    // pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
    // color output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // red[7:0], green[15:8], blue[23:16],
                                            // iteration_count[33:24], zero pad
    output logic                 m_tuser    // inside_set
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,  // wait for a pixel
        ST_CX   = 10'b00_0000_0010,  // multiply x offset by step
        ST_CY   = 10'b00_0000_0100,  // multiply y offset by step, form c_re
        ST_CW   = 10'b00_0000_1000,  // form c_im, clear z
        ST_CHK  = 10'b00_0001_0000,  // test limit, issue x*x
        ST_SQY  = 10'b00_0010_0000,  // issue y*y, take xx
        ST_XY   = 10'b00_0100_0000,  // issue x*y, take yy, escape test
        ST_UPD  = 10'b00_1000_0000,  // take xy, update z
        ST_DIV  = 10'b01_0000_0000,  // wait for it*255/limit
        ST_FIN  = 10'b10_0000_0000   // load output beat
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [COORD_W-1:0] center_real_reg;
    logic signed [COORD_W-1:0] center_imag_reg;
    logic [STEP_W-1:0]         pixel_step_reg;
    logic [DIM_W-1:0]          image_width_reg;
    logic [DIM_W-1:0]          image_height_reg;
    logic [ITER_W-1:0]         max_iter_reg;

    // per-pixel working registers
    logic [PIX_W-1:0]          px_reg;
    logic [PIX_W-1:0]          py_reg;
    logic signed [COORD_W-1:0] cre_reg;
    logic signed [COORD_W-1:0] cim_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [SQ_W-1:0]    xx_reg;
    logic [ITER_W-1:0]         it_reg;
    logic                      inside_reg;

    // output beat
    logic                      out_valid_reg;
    logic [COLOR_W-1:0]        red_reg;
    logic [COLOR_W-1:0]        green_reg;
    logic [COLOR_W-1:0]        blue_reg;
    logic [ITER_W-1:0]         out_it_reg;
    logic                      out_inside_reg;

    mul_req_t                  mul_req;
    logic signed [PROD_W-1:0]  prod;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic signed [DIM_W-1:0]   diff_x;
    logic signed [DIM_W-1:0]   diff_y;
    logic signed [SQ_W-1:0]    sq_now;
    logic signed [SQ_W:0]      mag;
    logic                      escape;
    logic                      out_free;
    logic                      in_beat;
    logic [COLOR_W-1:0]        t_val;

    mpc_mul_unit u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    mpc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // pixel offsets from the image center; both fit 11 bits signed
    always_comb
    begin
        diff_x = $signed({1'b0, px_reg}) - $signed({1'b0, image_width_reg[DIM_W-1:1]});
        diff_y = $signed({1'b0, py_reg}) - $signed({1'b0, image_height_reg[DIM_W-1:1]});
    end

    // product after floor shift, and the escape test on xx + yy
    always_comb
    begin
        sq_now = prod[PROD_W-1:FRAC_W];
        mag    = (SQ_W+1)'(xx_reg) + (SQ_W+1)'(sq_now);
        escape = mag > ESCAPE_LIMIT;
    end

    // steer the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_CX:
            begin
                mul_req.a = COORD_W'(diff_x);
                mul_req.b = $signed({1'b0, pixel_step_reg});
            end
            ST_CY:
            begin
                mul_req.a = COORD_W'(diff_y);
                mul_req.b = $signed({1'b0, pixel_step_reg});
            end
            ST_SQY:
            begin
                mul_req.a = y_reg;
                mul_req.b = y_reg;
            end
            ST_XY:
            begin
                mul_req.a = x_reg;
                mul_req.b = y_reg;
            end
            default:
            begin
                mul_req.a = x_reg;
                mul_req.b = x_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // start the divide on escape: it * 255 / limit
    always_comb
    begin
        div_req.start    = (state_reg == ST_XY) && escape;
        div_req.dividend = {it_reg, 8'd0} - DVD_W'(it_reg);
        div_req.divisor  = max_iter_reg;
    end

    assign t_val = div_rsp.quotient[COLOR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_beat) state_next = ST_CX;
            ST_CX:   state_next = ST_CY;
            ST_CY:   state_next = ST_CW;
            ST_CW:   state_next = ST_CHK;
            ST_CHK:  state_next = (it_reg >= max_iter_reg) ? ST_FIN : ST_SQY;
            ST_SQY:  state_next = ST_XY;
            ST_XY:   state_next = escape ? ST_DIV : ST_UPD;
            ST_UPD:  state_next = ST_CHK;
            ST_DIV:  if (div_rsp.done) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes; indexes past the list drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_real_reg  <= -32'sd161061274;
            center_imag_reg  <= '0;
            pixel_step_reg   <= STEP_W'(2863311);
            image_width_reg  <= DIM_W'(300);
            image_height_reg <= DIM_W'(220);
            max_iter_reg     <= ITER_W'(90);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_REAL: center_real_reg  <= cfg_data;
                REG_CENTER_IMAG: center_imag_reg  <= cfg_data;
                REG_PIXEL_STEP:  pixel_step_reg   <= cfg_data[STEP_W-1:0];
                REG_WIDTH:       image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:      image_height_reg <= cfg_data[DIM_W-1:0];
                REG_MAX_ITER:    max_iter_reg     <= cfg_data[ITER_W-1:0];
                default:         ;
            endcase
        end
    end

    // datapath: c, then z = z^2 + c with saturation
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                px_reg <= s_tdata[PIX_W-1:0];
                py_reg <= s_tdata[2*PIX_W-1:PIX_W];
            end
            ST_CY:
            begin
                cre_reg <= sat_coord(WIDE_W'(center_real_reg) + WIDE_W'(prod));
            end
            ST_CW:
            begin
                cim_reg    <= sat_coord(WIDE_W'(center_imag_reg) + WIDE_W'(prod));
                x_reg      <= '0;
                y_reg      <= '0;
                it_reg     <= '0;
                inside_reg <= 1'b0;
            end
            ST_CHK:
            begin
                // limit reached: the point counts as inside
                if (it_reg >= max_iter_reg)
                    inside_reg <= 1'b1;
            end
            ST_SQY:
            begin
                xx_reg <= sq_now;
            end
            ST_XY:
            begin
                // new real part from xx - yy + c_re, saturated; y follows in the update
                x_reg <= sat_coord(WIDE_W'(xx_reg) - WIDE_W'(sq_now) + WIDE_W'(cre_reg));
            end
            ST_UPD:
            begin
                y_reg  <= sat_coord((WIDE_W'(sq_now) <<< 1) + WIDE_W'(cim_reg));
                it_reg <= it_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // output register; a new pixel may enter while this beat waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_it_reg     <= it_reg;
            out_inside_reg <= inside_reg;
            if (inside_reg)
            begin
                red_reg   <= '0;
                green_reg <= '0;
                blue_reg  <= '0;
            end
            else
            begin
                red_reg   <= COLOR_W'(t_val * 8'd5);
                green_reg <= COLOR_W'(t_val * 8'd7 + 8'd40);
                blue_reg  <= COLOR_W'(t_val * 8'd11 + 8'd90);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_it_reg, blue_reg, green_reg, red_reg};
    assign m_tuser  = out_inside_reg;

    `MPC_ASSERT_NOW(a_escape_below_limit, state_reg == ST_XY, it_reg < max_iter_reg, "iteration ran at or past the limit")
    `MPC_ASSERT_NEXT(a_div_done_to_fin, (state_reg == ST_DIV) && div_rsp.done, state_reg == ST_FIN, "divide result not taken")
    `MPC_ASSERT_NOW(a_inside_black, m_tvalid && m_tuser, m_tdata[23:0] == 24'd0, "inside point not black")
    `MPC_ASSERT_NEXT(a_accept_starts, in_beat, state_reg == ST_CX, "accepted pixel did not start")

endmodule

// ===== test/tb_mandelbrot_pixel_colorizer.sv =====
`timescale 1ns / 100ps

module tb_mandelbrot_pixel_colorizer;
    import mpc_pkg::*;

    // Indexes past the last register: the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Q4.28 limits and the escape radius squared, at 64 bits.
    localparam longint Q_MAX    = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint Q_MIN    = -Q_MAX - 1;
    localparam longint ESCAPE_Q = longint'(4) <<< FRAC_W;

    // Nothing accepted for this long means the block hung. The slowest legal
    // gap is one inside point at the 1023 limit on top of the long receiver
    // hold-off and a stall burst on each side.
    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 600;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] x;
    } pixel_t;

    typedef struct packed {
        logic              in_set;
        logic [ITER_W-1:0] iters;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
    } pixel_color_t;

    // Our copy of the view registers, at the block's widths.
    typedef struct {
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
        logic [STEP_W-1:0]         step;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
        logic [ITER_W-1:0]         lim;
    } view_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // pixel_x[9:0], pixel_y[19:10], zero pad
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;          // red[7:0], green[15:8], blue[23:16],
                                            // iteration_count[33:24], zero pad
    logic                 m_tuser;          // inside_set

    view_t        view;
    pixel_t       pixel_queue[$];
    pixel_color_t pending_colors[$];
    pixel_t       cur_pixel;
    bit           offering;       // a pixel beat is on the bus or about to be
    bit           calm;           // no idling on either side from here on
    int           send_gap;
    int           stall_left;
    int           hold_left;
    int           held_at      = -1;
    int           results_seen = 0;
    int           errors       = 0;
    int           quiet_cycles;

    mandelbrot_pixel_colorizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Clamp an exact sum back into the signed Q4.28 range.
    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // Escape-time color of one pixel under the current view.
    function automatic pixel_color_t color_pixel(input pixel_t p);
        longint       c_re;
        longint       c_im;
        longint       zr;
        longint       zi;
        longint       rr;
        longint       ii;
        longint       ri;
        int unsigned  iters;
        int unsigned  shade;
        int unsigned  chan;
        pixel_color_t res;
        // Map the pixel onto the plane relative to the image center.
        c_re = clamp_q(longint'(view.re)
                       + (longint'(p.x) - longint'(view.w >> 1)) * longint'(view.step));
        c_im = clamp_q(longint'(view.im)
                       + (longint'(p.y) - longint'(view.h >> 1)) * longint'(view.step));
        zr = 0;
        zi = 0;
        iters = 0;
        while (iters < view.lim)
        begin
            // Arithmetic shift floors the products toward minus infinity.
            rr = (zr * zr) >>> FRAC_W;
            ii = (zi * zi) >>> FRAC_W;
            if (rr + ii > ESCAPE_Q)
                break;
            ri = (zr * zi) >>> FRAC_W;
            zr = clamp_q(rr - ii + c_re);
            zi = clamp_q(2 * ri + c_im);
            iters++;
        end
        res = '0;
        res.iters  = iters[ITER_W-1:0];
        res.in_set = (iters >= view.lim);
        // Inside points stay black; escaped ones index the palette ramp.
        if (!res.in_set)
        begin
            shade     = iters * 255 / view.lim;
            chan      = shade * 5;
            res.red   = chan[7:0];
            chan      = shade * 7 + 40;
            res.green = chan[7:0];
            chan      = shade * 11 + 90;
            res.blue  = chan[7:0];
        end
        return res;
    endfunction

    // Write one register and mirror it the way the block keeps it: low bits
    // only, spare indexes dropped.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CENTER_REAL: view.re   = data;
            REG_CENTER_IMAG: view.im   = data;
            REG_PIXEL_STEP:  view.step = data[STEP_W-1:0];
            REG_WIDTH:       view.w    = data[DIM_W-1:0];
            REG_HEIGHT:      view.h    = data[DIM_W-1:0];
            REG_MAX_ITER:    view.lim  = data[ITER_W-1:0];
            default:         ;
        endcase
    endtask

    // Program a whole view. Upper bits past each register's width carry
    // junk, and writes to the spare indexes are mixed in when asked.
    task automatic apply_view(input view_t v, input bit noisy);
        logic [COORD_W-1:0] data;
        if (noisy)
            write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_CENTER_REAL, v.re);
        write_reg(REG_CENTER_IMAG, v.im);
        data = $urandom;
        data[STEP_W-1:0] = v.step;
        write_reg(REG_PIXEL_STEP, data);
        if (noisy)
            write_reg(REG_SPARE_HI, $urandom);
        data = $urandom;
        data[DIM_W-1:0] = v.w;
        write_reg(REG_WIDTH, data);
        data = $urandom;
        data[DIM_W-1:0] = v.h;
        write_reg(REG_HEIGHT, data);
        data = $urandom;
        data[ITER_W-1:0] = v.lim;
        write_reg(REG_MAX_ITER, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly views near the set with scale/width steps, some wild ones
    // that push c into saturation, some with a tiny or zero limit.
    function automatic view_t random_view();
        view_t              v;
        longint             span_q;
        logic [COORD_W-1:0] bits;
        int unsigned        kind;
        kind = $urandom_range(0, 9);
        span_q = -590558003 + longint'($urandom_range(0, 751619277));
        v.re = span_q[COORD_W-1:0];
        span_q = -322122547 + longint'($urandom_range(0, 644245094));
        v.im = span_q[COORD_W-1:0];
        v.w = DIM_W'($urandom_range(16, 400));
        v.h = DIM_W'($urandom_range(16, 300));
        bits = $urandom_range(2684354, 1073741824) / v.w;
        v.step = bits[STEP_W-1:0];
        v.lim = ITER_W'($urandom_range(8, 120));
        if (kind == 7)
        begin
            v.re = $urandom;
            v.im = $urandom;
            bits = $urandom;
            v.step = bits[STEP_W-1:0];
            v.w = DIM_W'($urandom_range(0, 2047));
            v.h = DIM_W'($urandom_range(0, 2047));
            v.lim = ITER_W'($urandom_range(1, 40));
        end
        else if (kind == 8)
            v.lim = ITER_W'($urandom_range(0, 3));
        return v;
    endfunction

    // Pixel range worth aiming at for one image dimension.
    function automatic int unsigned span(input logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > 1024)
            return 1024;
        return d;
    endfunction

    task automatic queue_pixel(input int unsigned x, input int unsigned y);
        pixel_t p;
        p.x = PIX_W'(x);
        p.y = PIX_W'(y);
        pixel_queue.push_back(p);
    endtask

    // Most pixels land inside the image so the interesting points get hit;
    // the rest sweep the full coordinate range.
    task automatic queue_random_pixels(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                queue_pixel($urandom_range(0, span(view.w) - 1),
                            $urandom_range(0, span(view.h) - 1));
        end
    endtask

    // Hold until every queued pixel went in and every color came back before
    // touching the registers.
    task automatic wait_idle();
        @(posedge clk);
        while (pixel_queue.size() != 0 || pending_colors.size() != 0 || offering)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
    endtask

    // Pixel driver: hold a beat until it is taken, then pop the next one,
    // now and then after an idle burst.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            offering = 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pending_colors.push_back(color_pixel(cur_pixel));
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pixel_queue.size() != 0)
                begin
                    cur_pixel = pixel_queue.pop_front();
                    offering = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 14);
                end
            end
            s_tvalid <= offering;
            s_tdata  <= {4'b0, cur_pixel.y, cur_pixel.x};
        end
    end

    // Color monitor: check each result beat against the oldest prediction and
    // drive m_tready with short stall bursts plus two long hold-offs that
    // back the block up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_color_t got;
        pixel_color_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.red    = m_tdata[7:0];
                got.green  = m_tdata[15:8];
                got.blue   = m_tdata[23:16];
                got.iters  = m_tdata[33:24];
                got.in_set = m_tuser;
                if (pending_colors.size() == 0)
                begin
                    $display("%0t: unexpected color beat, expected none actual %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    if (got.red !== want.red)
                        report_field("red", want.red, got.red);
                    if (got.green !== want.green)
                        report_field("green", want.green, got.green);
                    if (got.blue !== want.blue)
                        report_field("blue", want.blue, got.blue);
                    if (got.iters !== want.iters)
                        report_field("iteration_count", want.iters, got.iters);
                    if (got.in_set !== want.in_set)
                        report_field("inside_set", want.in_set, got.in_set);
                end
                results_seen++;
            end
            if (hold_left > 0)
                hold_left--;
            else if ((results_seen == 60 || results_seen == 420) && held_at != results_seen)
            begin
                held_at   = results_seen;
                hold_left = LONG_HOLD;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (!calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 14);
            m_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("** mandelbrot_pixel_colorizer: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        view_t v;
        // Mirror the reset view; the block comes out of reset with it.
        view.re   = -161061274;
        view.im   = 0;
        view.step = 2863311;
        view.w    = 300;
        view.h    = 220;
        view.lim  = 90;
        calm      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset view: image center (deep inside), corners and far edges.
        queue_pixel(150, 110);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        queue_pixel(299, 219);
        wait_idle();

        // Zero limit: nothing iterates, every point is inside and black.
        v = view;
        v.lim = 0;
        apply_view(v, 1'b0);
        queue_pixel(150, 110);
        queue_pixel(0, 0);
        wait_idle();

        // Top limit: one full-length inside point, one slow escape.
        v.lim = 1023;
        apply_view(v, 1'b0);
        queue_pixel(150, 110);
        queue_pixel(40, 110);
        queue_pixel(0, 0);
        wait_idle();

        // Zero step collapses every pixel onto the view center; both spare
        // indexes get junk written along the way.
        v.lim  = 90;
        v.step = 0;
        v.re   = 32'sh1000_0000;
        v.im   = 32'sh0400_0000;
        apply_view(v, 1'b1);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        wait_idle();

        // Zero image size drops the centering offset.
        v.re   = -161061274;
        v.im   = 0;
        v.step = 2863311;
        v.w    = 0;
        v.h    = 0;
        apply_view(v, 1'b0);
        queue_pixel(0, 0);
        queue_pixel(512, 700);
        wait_idle();

        // Sizes past 1024 are used as written.
        v.w = 2047;
        v.h = 2047;
        apply_view(v, 1'b0);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        wait_idle();

        // Extreme center and step force c into saturation on both ends.
        v.re   = 32'sh7fff_ffff;
        v.im   = 32'sh8000_0000;
        v.step = 31'h7fff_ffff;
        v.w    = 2;
        v.h    = 2;
        v.lim  = 20;
        apply_view(v, 1'b0);
        queue_pixel(1023, 0);
        queue_pixel(0, 1023);
        queue_pixel(1023, 1023);
        wait_idle();

        // Random views, each with a batch of pixels.
        repeat (10)
        begin
            apply_view(random_view(), $urandom_range(0, 1));
            queue_random_pixels(62);
            wait_idle();
        end

        // Last stretch runs with no idling on either side.
        calm = 1'b1;
        v = random_view();
        v.lim = 64;
        apply_view(v, 1'b0);
        queue_random_pixels(60);
        wait_idle();

        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("** mandelbrot_pixel_colorizer: PASSED **");
        else
            $display("** mandelbrot_pixel_colorizer: FAILED **");
        $finish;
    end

endmodule
